[rtl/pr3d_pkg.sv]
// Shared payload types and fixed-point constants for the 3D point rotator.
package pr3d_pkg;

    typedef struct packed {
        logic        [1:0]  mode;
        logic signed [31:0] angle_deg;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [31:0] z_in;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } pr3d_in_t;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [31:0] z_out;
        logic               saturated;
    } pr3d_out_t;

    typedef enum logic [1:0] {
        MODE_X   = 2'd0,
        MODE_Y   = 2'd1,
        MODE_Z   = 2'd2,
        MODE_ARB = 2'd3
    } pr3d_mode_t;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [24:0] ONE_Q24     = 25'd16777216;
    // 360.0 in Q16.16 is 45 * 2^19
    localparam int          TURN_SHIFT  = 19;
    localparam logic [24:0] HALF_TURN   = 25'd11796480;
    // floor(2^16/45) and floor(2^24/45): both underestimate by less than one
    localparam logic [10:0] RECIP45_16  = 11'd1456;
    localparam logic [18:0] RECIP45_24  = 19'd372827;
    localparam logic [13:0] H_OFFSET    = 14'd4140;

endpackage

[rtl/point_rotation_3d.sv]
// Top level of the pipelined 3D point rotator (axis or Rodrigues matrix).
//
//  channel | ports                     | payload
//  --------+---------------------------+-----------------------------------
//  input   | s_valid, s_ready, s_data  | pr3d_in_t : mode, angle, point, axis
//  result  | m_valid, m_ready, m_data  | pr3d_out_t: rotated point, sat flag
//
// Eleven register stages; one transaction enters per cycle unless the result side stalls.
// Stage depth is set by the 30x32 coefficient products and the wide
// rounding adders; the sine table is a constant ROM read through a register.
// aresetn (synchronous) clears only the stage valid bits.
// A stall on the result side freezes every stage at once; s_ready drops only
// while the last stage holds a transaction that is not taken.
module point_rotation_3d
    import pr3d_pkg::*;
#(
    parameter int TRIG_TABLE_DEPTH = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pr3d_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output pr3d_out_t m_data
);

    localparam int D      = TRIG_TABLE_DEPTH;
    localparam int D4     = 4 * D;
    localparam int IDX_W  = $clog2(D + 1);
    localparam int PH_W   = $clog2(D4 + 1);
    localparam int ND_W   = $clog2(180 * D);
    localparam int PR_W   = ND_W + 19;
    localparam int NSTAGE = 11;

    // ---------------- sine table, Q24, built at elaboration
    function automatic logic [24:0] sine_q24(input logic [63:0] th);
        logic [63:0] th2, term, acc;
        th2  = (th * th) >> 30;
        term = th;
        acc  = th;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * th2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = (acc >= term) ? acc - term : 64'd0;
            end else begin
                acc = acc + term;
            end
        end
        acc = (acc + 64'd32) >> 6;
        if (acc > 64'(ONE_Q24)) begin
            acc = 64'(ONE_Q24);
        end
        return acc[24:0];
    endfunction

    logic [24:0] sine_rom [D + 1];

    for (genvar k = 0; k <= D; k++) begin : g_rom
        localparam logic [63:0] TH =
            (HALF_PI_Q30 * 64'(k) + 64'(TRIG_TABLE_DEPTH / 2)) / 64'(TRIG_TABLE_DEPTH);
        assign sine_rom[k] = sine_q24(TH);
    end

    // round to nearest, ties away from zero
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                        input int sh);
        logic [63:0] mag;
        mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    // quadrant fold of a phase into a table index and a sign
    function automatic logic [IDX_W:0] fold(input logic [PH_W-1:0] p);
        logic [PH_W-1:0] i;
        logic            ng;
        if (p < PH_W'(D)) begin
            i = p;                    ng = 1'b0;
        end else if (p < PH_W'(2 * D)) begin
            i = PH_W'(2 * D) - p;     ng = 1'b0;
        end else if (p < PH_W'(3 * D)) begin
            i = p - PH_W'(2 * D);     ng = 1'b1;
        end else begin
            i = PH_W'(D4) - p;        ng = 1'b1;
        end
        return {ng, i[IDX_W-1:0]};
    endfunction

    // ---------------- pipeline control
    logic [NSTAGE:1] valid_reg;
    logic            en;

    assign en      = !valid_reg[NSTAGE] || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg[NSTAGE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NSTAGE-1:1], s_valid};
        end
    end

    // point/axis/mode carried alongside
    logic        [1:0]  mode_reg [1:7];
    logic signed [31:0] p_reg    [1:8][3];
    logic signed [15:0] v_reg    [1:6][3];

    // ---------------- stage 1: angle mod 360 degrees, axis outer products
    logic [13:0]        h_off;
    logic [24:0]        hq_prod;
    logic [7:0]         q1;
    logic [13:0]        rem1_a, rem1;
    logic [24:0]        r_reg;
    logic signed [31:0] vv_reg [1:6][6];   // xx yy zz xy xz yz
    logic signed [15:0] ax, ay, az;

    assign ax      = s_data.axis_x;
    assign ay      = s_data.axis_y;
    assign az      = s_data.axis_z;
    assign h_off   = 14'($signed(s_data.angle_deg[31:19])) + H_OFFSET;
    assign hq_prod = h_off * RECIP45_16;
    assign q1      = hq_prod[23:16];
    assign rem1_a  = h_off - 14'(q1) * 14'd45;
    assign rem1    = (rem1_a >= 14'd45) ? rem1_a - 14'd45 : rem1_a;

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg          <= {rem1[5:0], s_data.angle_deg[18:0]};
            mode_reg[1]    <= s_data.mode;
            p_reg[1][0]    <= s_data.x_in;
            p_reg[1][1]    <= s_data.y_in;
            p_reg[1][2]    <= s_data.z_in;
            v_reg[1][0]    <= ax;
            v_reg[1][1]    <= ay;
            v_reg[1][2]    <= az;
            vv_reg[1][0]   <= 32'(ax) * 32'(ax);
            vv_reg[1][1]   <= 32'(ay) * 32'(ay);
            vv_reg[1][2]   <= 32'(az) * 32'(az);
            vv_reg[1][3]   <= 32'(ax) * 32'(ay);
            vv_reg[1][4]   <= 32'(ax) * 32'(az);
            vv_reg[1][5]   <= 32'(ay) * 32'(az);
        end
    end

    // ---------------- stage 2: scale to phase numerator, drop the 2^19 factor
    logic [47:0]     num;
    logic [ND_W-1:0] nd_reg [2:3];

    assign num = 48'(r_reg) * 48'(D4) + 48'(HALF_TURN);

    always_ff @(posedge aclk) begin
        if (en) begin
            nd_reg[2] <= ND_W'(num >> TURN_SHIFT);
        end
    end

    // ---------------- stage 3: reciprocal multiply for /45
    logic [PR_W-1:0] qp_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            qp_reg    <= PR_W'(nd_reg[2]) * PR_W'(RECIP45_24);
            nd_reg[3] <= nd_reg[2];
        end
    end

    // ---------------- stage 4: phase correction, quadrant fold
    logic [ND_W-1:0]  qe, rem4;
    logic [PH_W-1:0]  ph, ph_c_raw, ph_c;
    logic [IDX_W:0]   fs, fc;
    logic [IDX_W-1:0] sidx_reg, cidx_reg;
    logic             sneg_reg [4:5];
    logic             cneg_reg [4:5];

    always_comb begin
        qe   = ND_W'(qp_reg >> 24);
        rem4 = nd_reg[3] - ND_W'(qe * ND_W'(45));
        if (rem4 >= ND_W'(45)) begin
            qe = qe + 1'b1;
        end
        ph = (qe >= ND_W'(D4)) ? '0 : PH_W'(qe);
        ph_c_raw = ph + PH_W'(D);
        ph_c = (ph_c_raw >= PH_W'(D4)) ? ph_c_raw - PH_W'(D4) : ph_c_raw;
        fs = fold(ph);
        fc = fold(ph_c);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sidx_reg    <= fs[IDX_W-1:0];
            sneg_reg[4] <= fs[IDX_W];
            cidx_reg    <= fc[IDX_W-1:0];
            cneg_reg[4] <= fc[IDX_W];
        end
    end

    // ---------------- stage 5: table read
    logic [24:0] srom_reg, crom_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            srom_reg    <= sine_rom[sidx_reg];
            crom_reg    <= sine_rom[cidx_reg];
            sneg_reg[5] <= sneg_reg[4];
            cneg_reg[5] <= cneg_reg[4];
        end
    end

    // ---------------- stage 6: signed sine and cosine
    logic signed [25:0] s_reg [6:7];
    logic signed [25:0] c_reg [6:7];

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg[6] <= sneg_reg[5] ? -$signed({1'b0, srom_reg}) : $signed({1'b0, srom_reg});
            c_reg[6] <= cneg_reg[5] ? -$signed({1'b0, crom_reg}) : $signed({1'b0, crom_reg});
        end
    end

    // ---------------- stage 7: Rodrigues products
    logic signed [26:0] omc;
    logic signed [57:0] ovv_reg [6];
    logic signed [41:0] sv_reg  [3];

    assign omc = 27'($signed({2'b0, ONE_Q24})) - 27'(c_reg[6]);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 6; j++) begin
                ovv_reg[j] <= 58'(omc) * 58'(vv_reg[6][j]);
            end
            for (int j = 0; j < 3; j++) begin
                sv_reg[j] <= 42'(s_reg[6]) * 42'(v_reg[6][j]);
            end
            s_reg[7] <= s_reg[6];
            c_reg[7] <= c_reg[6];
        end
    end

    // ---------------- stage 8: matrix assembly
    logic signed [29:0] m_next [3][3];
    logic signed [29:0] m_reg  [3][3];
    logic signed [29:0] rv     [6];
    logic signed [29:0] rs     [3];
    logic signed [29:0] sx, cx, one_x;

    always_comb begin
        sx    = 30'(s_reg[7]);
        cx    = 30'(c_reg[7]);
        one_x = $signed({5'b0, ONE_Q24});
        for (int j = 0; j < 6; j++) begin
            rv[j] = 30'(round_shift(64'(ovv_reg[j]), 28));
        end
        for (int j = 0; j < 3; j++) begin
            rs[j] = 30'(round_shift(64'(sv_reg[j]), 14));
        end
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                m_next[a][b] = '0;
            end
        end
        unique case (pr3d_mode_t'(mode_reg[7]))
            MODE_X: begin
                m_next[0][0] = one_x;
                m_next[1][1] = cx;  m_next[1][2] = -sx;
                m_next[2][1] = sx;  m_next[2][2] = cx;
            end
            MODE_Y: begin
                m_next[0][0] = cx;  m_next[0][2] = sx;
                m_next[1][1] = one_x;
                m_next[2][0] = -sx; m_next[2][2] = cx;
            end
            MODE_Z: begin
                m_next[0][0] = cx;  m_next[0][1] = -sx;
                m_next[1][0] = sx;  m_next[1][1] = cx;
                m_next[2][2] = one_x;
            end
            MODE_ARB: begin
                m_next[0][0] = rv[0] + cx;
                m_next[1][1] = rv[1] + cx;
                m_next[2][2] = rv[2] + cx;
                m_next[0][1] = rv[3] - rs[2];
                m_next[1][0] = rv[3] + rs[2];
                m_next[0][2] = rv[4] + rs[1];
                m_next[2][0] = rv[4] - rs[1];
                m_next[1][2] = rv[5] - rs[0];
                m_next[2][1] = rv[5] + rs[0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg <= m_next;
        end
    end

    // ---------------- stage 9: coefficient times coordinate
    logic signed [61:0] mp_reg [3][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    mp_reg[a][b] <= 62'(m_reg[a][b]) * 62'(p_reg[8][b]);
                end
            end
        end
    end

    // ---------------- stage 10: row sums
    logic signed [63:0] acc_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                acc_reg[a] <= 64'(mp_reg[a][0]) + 64'(mp_reg[a][1]) + 64'(mp_reg[a][2]);
            end
        end
    end

    // ---------------- stage 11: round to Q16.16, saturate
    logic signed [63:0] rnd [3];
    logic signed [31:0] res [3];
    logic        [2:0]  clip;
    pr3d_out_t          out_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rnd[a] = round_shift(acc_reg[a], 24);
            if (rnd[a] > 64'sd2147483647) begin
                res[a] = 32'sh7fffffff; clip[a] = 1'b1;
            end else if (rnd[a] < -64'sd2147483648) begin
                res[a] = 32'sh80000000; clip[a] = 1'b1;
            end else begin
                res[a] = rnd[a][31:0];  clip[a] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.x_out     <= res[0];
            out_reg.y_out     <= res[1];
            out_reg.z_out     <= res[2];
            out_reg.saturated <= |clip;
        end
    end

    assign m_data = out_reg;

    // ---------------- sideband delay lines
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int st = 2; st <= 7; st++) begin
                mode_reg[st] <= mode_reg[st-1];
            end
            for (int st = 2; st <= 8; st++) begin
                p_reg[st] <= p_reg[st-1];
            end
            for (int st = 2; st <= 6; st++) begin
                v_reg[st] <= v_reg[st-1];
            end
            for (int st = 2; st <= 6; st++) begin
                vv_reg[st] <= vv_reg[st-1];
            end
        end
    end

endmodule

[rtl/pr3d_checker.sv]
// Port-level checker for the 3D point rotator, bound to the top level.
module pr3d_checker
    import pr3d_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input pr3d_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input pr3d_out_t m_data
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while pipeline stalled");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with no pending result");

endmodule

bind point_rotation_3d pr3d_checker u_pr3d_checker (.*);

[tb/point_rotation_3d_test.sv]
// Testbench for the pipelined 3D point rotator.
module point_rotation_3d_test;
    import pr3d_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int LATENCY   = 11;
    localparam int MAX_CYCLES = 400000;
    localparam longint TURN_Q16 = 64'sd23592960;
    localparam longint UNIT_Q24 = 64'sd16777216;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    pr3d_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    pr3d_out_t m_data;

    point_rotation_3d #(.TRIG_TABLE_DEPTH(DEPTH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // quarter-wave sine table in Q24, built like the block's ROM
    longint    quarter_sine[DEPTH+1];
    pr3d_out_t rotated_points[$];
    int        mismatch_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // cycle counter doubles as the watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void build_quarter_sine();
        longint unsigned th, th2, term, acc;
        for (int k = 0; k <= DEPTH; k++) begin
            th   = (64'd1686629713 * k + DEPTH / 2) / DEPTH;
            th2  = (th * th) >> 30;
            term = th;
            acc  = th;
            for (int n = 1; n <= 10; n++) begin
                term = ((term * th2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) acc = (acc >= term) ? acc - term : 64'd0;
                else            acc = acc + term;
            end
            acc = (acc + 32) >> 6;
            if (acc > UNIT_Q24) acc = UNIT_Q24;
            quarter_sine[k] = longint'(acc);
        end
    endfunction

    function automatic longint sine_of_phase(longint ph);
        longint q, i;
        ph = ph % (4 * DEPTH);
        q  = ph / DEPTH;
        i  = ph % DEPTH;
        case (q)
            0:       return quarter_sine[i];
            1:       return quarter_sine[DEPTH - i];
            2:       return -quarter_sine[i];
            default: return -quarter_sine[DEPTH - i];
        endcase
    endfunction

    // round to nearest, ties away from zero
    function automatic longint round_away(longint v, int sh);
        longint unsigned mag;
        mag = (v < 0) ? longint'(-v) : v;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // 64-bit signed multiply producing a 128-bit product is not needed:
    // coefficients stay within ~2^27 and coordinates within 2^31
    function automatic pr3d_out_t rotate_point(pr3d_in_t t);
        pr3d_out_t res;
        longint ang, r, s, c, omc, acc, val;
        longint unsigned ph;
        longint p[3], v[3], sv[3], m[3][3];
        logic sat;
        sat = 1'b0;
        ang = longint'(t.angle_deg);
        p[0] = t.x_in; p[1] = t.y_in; p[2] = t.z_in;
        v[0] = t.axis_x; v[1] = t.axis_y; v[2] = t.axis_z;
        r = ang % TURN_Q16;
        if (r < 0) r += TURN_Q16;
        ph = (longint'(r) * (4 * DEPTH) + TURN_Q16 / 2) / TURN_Q16;
        if (ph >= 4 * DEPTH) ph = 0;
        s = sine_of_phase(ph);
        c = sine_of_phase(ph + DEPTH);
        foreach (m[i, j]) m[i][j] = 0;
        case (pr3d_mode_t'(t.mode))
            MODE_X: begin
                m[0][0] = UNIT_Q24;
                m[1][1] = c; m[1][2] = -s;
                m[2][1] = s; m[2][2] = c;
            end
            MODE_Y: begin
                m[0][0] = c;  m[0][2] = s;
                m[1][1] = UNIT_Q24;
                m[2][0] = -s; m[2][2] = c;
            end
            MODE_Z: begin
                m[0][0] = c; m[0][1] = -s;
                m[1][0] = s; m[1][1] = c;
                m[2][2] = UNIT_Q24;
            end
            default: begin
                omc = UNIT_Q24 - c;
                for (int i = 0; i < 3; i++) begin
                    sv[i] = round_away(s * v[i], 14);
                    for (int j = 0; j < 3; j++)
                        m[i][j] = round_away(omc * (v[i] * v[j]), 28);
                    m[i][i] += c;
                end
                m[0][1] -= sv[2]; m[0][2] += sv[1];
                m[1][0] += sv[2]; m[1][2] -= sv[0];
                m[2][0] -= sv[1]; m[2][1] += sv[0];
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            acc = m[i][0] * p[0] + m[i][1] * p[1] + m[i][2] * p[2];
            val = round_away(acc, 24);
            if (val > 64'sd2147483647) begin
                val = 64'sd2147483647; sat = 1'b1;
            end else if (val < -64'sd2147483648) begin
                val = -64'sd2147483648; sat = 1'b1;
            end
            case (i)
                0: res.x_out = val[31:0];
                1: res.y_out = val[31:0];
                default: res.z_out = val[31:0];
            endcase
        end
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // send one transaction; valid held until accepted, dropped only in gaps
    task automatic send_point(pr3d_in_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        rotated_points.push_back(rotate_point(t));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // result side: random stalls, compare against the oldest expectation
    always @(posedge aclk) begin
        pr3d_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (rotated_points.size() == 0) begin
                    $display("unexpected result transaction");
                    mismatch_count++;
                end else begin
                    want = rotated_points.pop_front();
                    if (m_data.x_out !== want.x_out)
                        report_mismatch("x_out", m_data.x_out, want.x_out);
                    if (m_data.y_out !== want.y_out)
                        report_mismatch("y_out", m_data.y_out, want.y_out);
                    if (m_data.z_out !== want.z_out)
                        report_mismatch("z_out", m_data.z_out, want.z_out);
                    if (m_data.saturated !== want.saturated)
                        report_mismatch("saturated", m_data.saturated, want.saturated);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic pr3d_in_t random_point(logic [1:0] md);
        pr3d_in_t t;
        t.mode = md;
        // mostly angles within one turn either way, sometimes the full 32-bit range
        t.angle_deg = ($urandom_range(3) == 0) ? $urandom :
                      $signed($urandom_range(47185920)) - 32'sd23592960;
        case ($urandom_range(3))
            0:       t.x_in = $urandom;
            default: t.x_in = $signed($urandom_range(2097152)) - 32'sd1048576;
        endcase
        t.y_in = ($urandom_range(3) == 0) ? $urandom :
                 $signed($urandom_range(2097152)) - 32'sd1048576;
        t.z_in = ($urandom_range(3) == 0) ? $urandom :
                 $signed($urandom_range(2097152)) - 32'sd1048576;
        t.axis_x = 16'($urandom); t.axis_y = 16'($urandom); t.axis_z = 16'($urandom);
        if (md == MODE_ARB && $urandom_range(1)) begin
            // roughly unit axes along one coordinate, with random sign
            t.axis_x = '0; t.axis_y = '0; t.axis_z = '0;
            case ($urandom_range(2))
                0: t.axis_x = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                1: t.axis_y = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                default: t.axis_z = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            endcase
        end
        return t;
    endfunction

    task automatic test_directed();
        pr3d_in_t t;
        int angles[6] = '{0, 32'sd5898240, 32'sd23592960, -32'sd5898240,
                          32'h7fffffff, 32'h80000000};
        for (int md = 0; md < 4; md++) begin
            foreach (angles[k]) begin
                t.mode = 2'(md);
                t.angle_deg = angles[k];
                t.x_in = (k % 2) ? 32'h7fffffff : 32'sd65536;
                t.y_in = (k % 3 == 0) ? 32'h80000000 : -32'sd131072;
                t.z_in = 32'sd196608;
                // axis garbage in modes 0..2, non-unit or unit axis in mode 3
                t.axis_x = (k == 4) ? 16'h7fff : 16'sd16384;
                t.axis_y = (k == 5) ? 16'h8000 : 16'sd0;
                t.axis_z = 16'hffff;
                if (md == MODE_ARB && k < 3) t.axis_z = '0;
                send_point(t);
            end
        end
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
            send_point(random_point(2'($urandom_range(3))));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (rotated_points.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    initial begin
        build_quarter_sine();
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(325);
        send_idle_pct = 58;
        test_random(325);
        send_idle_pct = 0; recv_stall_pct = 58;
        test_random(325);
        send_idle_pct = 6; recv_stall_pct = 6;
        test_random(325);
        drain();

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/pr3d_pkg.sv
rtl/point_rotation_3d.sv
rtl/pr3d_checker.sv
tb/point_rotation_3d_test.sv
